// ----- hw/rtl/cdiv_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex divider package
// Shared widths, sideband records, status codes and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package cdiv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int QBITS   = DATA_WIDTH;
    localparam int DEN_W   = DATA_WIDTH + 2;
    localparam int NUM_W   = DATA_WIDTH + FRAC_BITS + 2;
    localparam int DIV_LAT = QBITS + 1;
    localparam int RATIO_W = FRAC_BITS + 2;
    localparam int PROD_W  = RATIO_W + DATA_WIDTH;
    localparam int SUM_W   = DATA_WIDTH + 2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SAT      = 2'd1,
        STATUS_DIV_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic                         zero;
        logic                         swap;
        logic                         rneg;
        logic signed [DATA_WIDTH-1:0] l_val;
        logic signed [DATA_WIDTH-1:0] s_val;
        logic signed [DATA_WIDTH-1:0] x_real;
        logic signed [DATA_WIDTH-1:0] x_imag;
    } ratio_side_t;

    typedef struct packed {
        logic zero;
        logic neg_re;
        logic neg_im;
    } quot_side_t;

    // Signed product divided by 2^FRAC_BITS with truncation toward zero.
    function automatic logic signed [SUM_W-1:0] shr_trunc(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p[PROD_W-1] ? p + PROD_W'((64'd1 << FRAC_BITS) - 64'd1) : p;
        return SUM_W'(b >>> FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cdiv_operand_if.sv -----
// ----------------------------------------------------------------------------
// Complex divider operand channel
// Carries one dividend and one divisor per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdiv_operand_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cdiv_pkg::DATA_WIDTH-1:0] x_real;
    logic signed [cdiv_pkg::DATA_WIDTH-1:0] x_imag;
    logic signed [cdiv_pkg::DATA_WIDTH-1:0] y_real;
    logic signed [cdiv_pkg::DATA_WIDTH-1:0] y_imag;

    modport source(output valid, x_real, x_imag, y_real, y_imag, input ready);
    modport sink(input valid, x_real, x_imag, y_real, y_imag, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cdiv_quotient_if.sv -----
// ----------------------------------------------------------------------------
// Complex divider quotient channel
// Carries one quotient and its status per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdiv_quotient_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cdiv_pkg::DATA_WIDTH-1:0] q_real;
    logic signed [cdiv_pkg::DATA_WIDTH-1:0] q_imag;
    logic [1:0]                             status;

    modport source(output valid, q_real, q_imag, status, input ready);
    modport sink(input valid, q_real, q_imag, status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cdiv_divider.sv -----
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with an up-front check
// that flags quotients that do not fit QBITS bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cdiv_divider (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [cdiv_pkg::NUM_W-1:0]     num,
    input  wire logic [cdiv_pkg::DEN_W-1:0]     den,
    output logic      [cdiv_pkg::QBITS-1:0]     quo,
    output logic                                ovf
);

    localparam int QB    = cdiv_pkg::QBITS;
    localparam int DW    = cdiv_pkg::DEN_W;
    localparam int NW    = cdiv_pkg::NUM_W;
    localparam int CMP_W = DW + QB;

    logic [DW-1:0] rem_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [QB-1:0] quo_reg [0:QB];
    logic [DW-1:0] den_reg [0:QB];
    logic          ovf_reg [0:QB];

    logic [DW-1:0] rem_next [0:QB-1];
    logic          bit_next [0:QB-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num[NW-1:QB]);
            low_reg[0] <= num[QB-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << QB);
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DW:0]   part;
        logic [DW+1:0] diff;

        always_comb
        begin
            part        = {rem_reg[k], low_reg[k][QB-1]};
            diff        = {1'b0, part} - {2'b00, den_reg[k]};
            bit_next[k] = ~diff[DW+1];
            rem_next[k] = bit_next[k] ? diff[DW-1:0] : part[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next[k];
                low_reg[k+1] <= {low_reg[k][QB-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][QB-2:0], bit_next[k]};
                den_reg[k+1] <= den_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quo = quo_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

`default_nettype wire

// ----- hw/rtl/complex_divide_core.sv -----
// ----------------------------------------------------------------------------
// Complex divide core
// Smith's complex division in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// The core accepts one request per clock while the output is not held and
// returns the quotients in order.
// The pipeline is made of two bit-serial divider pipelines of DATA_WIDTH+1
// stages each, one for the ratio and one pair for the quotient parts, plus
// four stages for operand selection, the products, the sums and the output.
// The whole pipeline stalls together when the output is held.
`default_nettype none

module complex_divide_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cdiv_operand_if.sink    operands,
    cdiv_quotient_if.source quotient
);

    localparam int W  = cdiv_pkg::DATA_WIDTH;
    localparam int F  = cdiv_pkg::FRAC_BITS;
    localparam int DL = cdiv_pkg::DIV_LAT;
    localparam int RW = cdiv_pkg::RATIO_W;
    localparam int PW = cdiv_pkg::PROD_W;
    localparam int SW = cdiv_pkg::SUM_W;
    localparam int NW = cdiv_pkg::NUM_W;
    localparam int DW = cdiv_pkg::DEN_W;

    localparam logic [W-1:0] HALF = W'(1) << (W - 1);
    localparam logic [W-1:0] QMAX = HALF - W'(1);

    logic en;

    // Operand selection.
    logic [W:0] yr_mag, yi_mag;
    cdiv_pkg::ratio_side_t s1_next, s1_reg;
    logic                  s1_valid_reg;

    always_comb
    begin
        yr_mag = operands.y_real[W-1] ? -{1'b1, operands.y_real} : {1'b0, operands.y_real};
        yi_mag = operands.y_imag[W-1] ? -{1'b1, operands.y_imag} : {1'b0, operands.y_imag};
        s1_next.zero   = (operands.y_real == '0) && (operands.y_imag == '0);
        s1_next.swap   = yr_mag < yi_mag;
        s1_next.l_val  = s1_next.swap ? operands.y_imag : operands.y_real;
        s1_next.s_val  = s1_next.swap ? operands.y_real : operands.y_imag;
        s1_next.rneg   = s1_next.l_val[W-1] ^ s1_next.s_val[W-1];
        s1_next.x_real = operands.x_real;
        s1_next.x_imag = operands.x_imag;
    end

    // Ratio divider.
    logic [W-1:0]  s_mag, l_mag;
    logic [W-1:0]  r_quo;
    logic          r_ovf;
    cdiv_pkg::ratio_side_t a_side_reg [0:DL-1];
    logic                  a_valid_reg [0:DL-1];

    assign s_mag = s1_reg.s_val[W-1] ? -s1_reg.s_val : s1_reg.s_val;
    assign l_mag = s1_reg.l_val[W-1] ? -s1_reg.l_val : s1_reg.l_val;

    cdiv_divider u_ratio_div (
        .clk (clk),
        .en  (en),
        .num (NW'(s_mag) << F),
        .den (DW'(l_mag)),
        .quo (r_quo),
        .ovf (r_ovf)
    );

    // Products.
    logic signed [PW-1:0] r_ext, ls_ext, xr_ext, xi_ext;
    logic signed [PW-1:0] p_s_reg, p_xr_reg, p_xi_reg;
    cdiv_pkg::ratio_side_t s2_reg;
    logic                  s2_valid_reg;

    always_comb
    begin
        r_ext  = a_side_reg[DL-1].rneg ? -PW'(r_quo[RW-2:0]) : PW'(r_quo[RW-2:0]);
        ls_ext = PW'(a_side_reg[DL-1].s_val);
        xr_ext = PW'(a_side_reg[DL-1].x_real);
        xi_ext = PW'(a_side_reg[DL-1].x_imag);
    end

    // Denominator and numerators.
    logic signed [SW-1:0] t_s, t_xr, t_xi, xr_s, xi_s;
    logic signed [SW-1:0] den_next, nre_next, nim_next;
    logic signed [SW-1:0] den_reg, nre_reg, nim_reg;
    logic                 s3_zero_reg;
    logic                 s3_valid_reg;

    always_comb
    begin
        t_s      = cdiv_pkg::shr_trunc(p_s_reg);
        t_xr     = cdiv_pkg::shr_trunc(p_xr_reg);
        t_xi     = cdiv_pkg::shr_trunc(p_xi_reg);
        xr_s     = SW'(s2_reg.x_real);
        xi_s     = SW'(s2_reg.x_imag);
        den_next = SW'(s2_reg.l_val) + t_s;
        nre_next = s2_reg.swap ? t_xr + xi_s : xr_s + t_xi;
        nim_next = s2_reg.swap ? t_xi - xr_s : xi_s - t_xr;
    end

    // Quotient dividers.
    logic [SW-1:0] den_mag, nre_mag, nim_mag;
    logic [W-1:0]  qre_quo, qim_quo;
    logic          qre_ovf, qim_ovf;
    cdiv_pkg::quot_side_t b_side_next;
    cdiv_pkg::quot_side_t b_side_reg [0:DL-1];
    logic                 b_valid_reg [0:DL-1];

    always_comb
    begin
        den_mag = den_reg[SW-1] ? -den_reg : den_reg;
        nre_mag = nre_reg[SW-1] ? -nre_reg : nre_reg;
        nim_mag = nim_reg[SW-1] ? -nim_reg : nim_reg;
        b_side_next.zero   = s3_zero_reg;
        b_side_next.neg_re = nre_reg[SW-1] ^ den_reg[SW-1];
        b_side_next.neg_im = nim_reg[SW-1] ^ den_reg[SW-1];
    end

    cdiv_divider u_real_div (
        .clk (clk),
        .en  (en),
        .num (NW'(nre_mag) << F),
        .den (DW'(den_mag)),
        .quo (qre_quo),
        .ovf (qre_ovf)
    );

    cdiv_divider u_imag_div (
        .clk (clk),
        .en  (en),
        .num (NW'(nim_mag) << F),
        .den (DW'(den_mag)),
        .quo (qim_quo),
        .ovf (qim_ovf)
    );

    // Saturation and output.
    logic signed [W-1:0] qre_next, qim_next;
    logic                sat_re, sat_im;
    cdiv_pkg::status_t   status_next;
    logic signed [W-1:0] qre_reg, qim_reg;
    cdiv_pkg::status_t   status_reg;
    logic                out_valid_reg;

    always_comb
    begin
        if (b_side_reg[DL-1].neg_re)
        begin
            sat_re   = qre_ovf || (qre_quo > HALF);
            qre_next = sat_re ? HALF : -qre_quo;
        end
        else
        begin
            sat_re   = qre_ovf || qre_quo[W-1];
            qre_next = sat_re ? QMAX : qre_quo;
        end
        if (b_side_reg[DL-1].neg_im)
        begin
            sat_im   = qim_ovf || (qim_quo > HALF);
            qim_next = sat_im ? HALF : -qim_quo;
        end
        else
        begin
            sat_im   = qim_ovf || qim_quo[W-1];
            qim_next = sat_im ? QMAX : qim_quo;
        end
        if (b_side_reg[DL-1].zero)
        begin
            qre_next    = '0;
            qim_next    = '0;
            status_next = cdiv_pkg::STATUS_DIV_ZERO;
        end
        else if (sat_re || sat_im)
        begin
            status_next = cdiv_pkg::STATUS_SAT;
        end
        else
        begin
            status_next = cdiv_pkg::STATUS_OK;
        end
    end

    assign en              = !out_valid_reg || quotient.ready;
    assign operands.ready  = en;
    assign quotient.valid  = out_valid_reg;
    assign quotient.q_real = qre_reg;
    assign quotient.q_imag = qim_reg;
    assign quotient.status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DL; k++)
            begin
                a_valid_reg[k] <= 1'b0;
                b_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg   <= operands.valid;
            a_valid_reg[0] <= s1_valid_reg;
            for (int k = 1; k < DL; k++)
            begin
                a_valid_reg[k] <= a_valid_reg[k-1];
                b_valid_reg[k] <= b_valid_reg[k-1];
            end
            s2_valid_reg   <= a_valid_reg[DL-1];
            s3_valid_reg   <= s2_valid_reg;
            b_valid_reg[0] <= s3_valid_reg;
            out_valid_reg  <= b_valid_reg[DL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg        <= s1_next;
            a_side_reg[0] <= s1_reg;
            for (int k = 1; k < DL; k++)
            begin
                a_side_reg[k] <= a_side_reg[k-1];
                b_side_reg[k] <= b_side_reg[k-1];
            end
            s2_reg        <= a_side_reg[DL-1];
            p_s_reg       <= r_ext * ls_ext;
            p_xr_reg      <= r_ext * xr_ext;
            p_xi_reg      <= r_ext * xi_ext;
            den_reg       <= den_next;
            nre_reg       <= nre_next;
            nim_reg       <= nim_next;
            s3_zero_reg   <= s2_reg.zero;
            b_side_reg[0] <= b_side_next;
            qre_reg       <= qre_next;
            qim_reg       <= qim_next;
            status_reg    <= status_next;
        end
    end

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        quotient.valid && (quotient.status == cdiv_pkg::STATUS_DIV_ZERO)
        |-> (quotient.q_real == '0) && (quotient.q_imag == '0))
        else $error("Zero divisor gave a nonzero quotient.");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        quotient.valid && (quotient.status == cdiv_pkg::STATUS_SAT)
        |-> (quotient.q_real == HALF) || (quotient.q_real == QMAX)
            || (quotient.q_imag == HALF) || (quotient.q_imag == QMAX))
        else $error("Saturated status without a clamped part.");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        quotient.valid && !quotient.ready |-> !operands.ready)
        else $error("Request taken while the pipeline is stalled.");

    a_ratio_fit: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg[DL-1] && !a_side_reg[DL-1].zero |-> !r_ovf)
        else $error("Ratio quotient overflowed.");

endmodule

`default_nettype wire
